// File: hw/rtl/bb3_pkg.sv
// bb3_pkg: shared types, sizes and the reciprocal table for the 3x3 box blur.
// Used by bb3_ctrl, bb3_dp and box_blur_3x3_edge_clamped.
package bb3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int AW           = $clog2(MAX_WIDTH);
    localparam int EW           = AW + 1;
    localparam int WW           = 11;
    localparam int HW           = 13;
    localparam int RW           = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int RECIP_BITS   = 20;
    localparam int SUM_BITS     = 12;
    localparam int X_BITS       = SUM_BITS + 1;
    localparam int PROD_BITS    = X_BITS + RECIP_BITS;

    localparam logic [WW-1:0] WIDTH_RESET  = WW'(1024);
    localparam logic [HW-1:0] HEIGHT_RESET = HW'(768);

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pix_t;

    // One averaging job: which window columns to use and which rows/cols count.
    typedef struct packed {
        logic shift;
        logic rok0;
        logic rok2;
        logic cok0;
        logic cok2;
        logic frame_end;
        logic run_end;
    } emit_t;

    typedef struct packed {
        logic          take;
        logic          ld;
        logic          we;
        logic          go;
        emit_t         em;
        logic [AW-1:0] addr;
    } bb3_cmd_t;

    typedef struct packed {
        logic idle;
        logic out_done;
    } bb3_sts_t;

    // ceil(2^20 / (2n)); exact for 2*sum+n below 2^13
    function automatic logic [RECIP_BITS-1:0] recip(input logic [3:0] n);
        logic [RECIP_BITS-1:0] v;
        case (n)
            4'd1:    v = 20'd524288;
            4'd2:    v = 20'd262144;
            4'd3:    v = 20'd174763;
            4'd4:    v = 20'd131072;
            4'd5:    v = 20'd104858;
            4'd6:    v = 20'd87382;
            4'd7:    v = 20'd74899;
            4'd8:    v = 20'd65536;
            4'd9:    v = 20'd58255;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/bb3_ctrl.sv
// bb3_ctrl: sequencer for the box blur; frame counters, line store
// addressing and averaging job issue. Depends on bb3_pkg.
module bb3_ctrl
    import bb3_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic          item_drain,
    input  logic [WW-1:0] image_width,
    input  logic [HW-1:0] image_height,
    input  bb3_sts_t      sts,
    output bb3_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P_RD,
        ST_P_LD,
        ST_D_RD0,
        ST_D_RD1,
        ST_D_RD2,
        ST_D_LD,
        ST_EMIT,
        ST_WAIT
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [AW-1:0] drain_reg, drain_next;
    logic          draining_reg, draining_next;
    logic [AW-1:0] addr_reg, addr_next;
    emit_t         em1_reg, em1_next;
    emit_t         em2_reg, em2_next;
    logic          pend1_reg, pend1_next;
    logic          pend2_reg, pend2_next;

    logic [EW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          last_col;
    logic          last_row;
    logic          last_drain;

    always_comb
    begin
        if (image_width == '0)
            eff_w = EW'(1);
        else if (32'(image_width) > MAX_WIDTH)
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(image_width);

        if (image_height == '0)
            eff_h = HW'(1);
        else if (32'(image_height) > HEIGHT_LIMIT)
            eff_h = HW'(HEIGHT_LIMIT);
        else
            eff_h = image_height;
    end

    assign last_col   = ({1'b0, col_reg} + EW'(1)) >= eff_w;
    assign last_row   = ({1'b0, row_reg} + HW'(1)) >= eff_h;
    assign last_drain = ({1'b0, drain_reg} + EW'(1)) >= eff_w;

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        draining_next = draining_reg;
        addr_next     = addr_reg;
        em1_next      = em1_reg;
        em2_next      = em2_reg;
        pend1_next    = pend1_reg;
        pend2_next    = pend2_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (item_drain && draining_reg)
                    begin
                        addr_next          = drain_reg - AW'(1);
                        em1_next.shift     = 1'b0;
                        em1_next.rok0      = row_reg != '0;
                        em1_next.rok2      = 1'b0;
                        em1_next.cok0      = drain_reg != '0;
                        em1_next.cok2      = !last_drain;
                        em1_next.frame_end = last_drain;
                        em1_next.run_end   = 1'b1;
                        pend1_next         = 1'b1;
                        pend2_next         = 1'b0;
                        state_next         = ST_D_RD0;
                        if (last_drain)
                        begin
                            draining_next = 1'b0;
                            col_next      = '0;
                            row_next      = '0;
                            drain_next    = '0;
                        end
                        else
                        begin
                            drain_next = drain_reg + AW'(1);
                        end
                    end
                    else if (!item_drain && !draining_reg)
                    begin
                        addr_next          = col_reg;
                        em1_next.shift     = 1'b0;
                        em1_next.rok0      = row_reg >= RW'(2);
                        em1_next.rok2      = 1'b1;
                        em1_next.cok0      = col_reg >= AW'(2);
                        em1_next.cok2      = 1'b1;
                        em1_next.frame_end = 1'b0;
                        em1_next.run_end   = !last_col;
                        em2_next.shift     = 1'b1;
                        em2_next.rok0      = row_reg >= RW'(2);
                        em2_next.rok2      = 1'b1;
                        em2_next.cok0      = col_reg != '0;
                        em2_next.cok2      = 1'b0;
                        em2_next.frame_end = 1'b0;
                        em2_next.run_end   = 1'b1;
                        pend1_next         = (row_reg != '0) && (col_reg != '0);
                        pend2_next         = (row_reg != '0) && last_col;
                        state_next         = ST_P_RD;
                        if (last_col)
                        begin
                            col_next = '0;
                            if (last_row)
                            begin
                                draining_next = 1'b1;
                                drain_next    = '0;
                            end
                            else
                            begin
                                row_next = row_reg + RW'(1);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + AW'(1);
                        end
                    end
                end
            end
            ST_P_RD:
                state_next = ST_P_LD;
            ST_P_LD:
                state_next = (pend1_reg || pend2_reg) ? ST_EMIT : ST_IDLE;
            ST_D_RD0:
            begin
                addr_next  = addr_reg + AW'(1);
                state_next = ST_D_RD1;
            end
            ST_D_RD1:
            begin
                addr_next  = addr_reg + AW'(1);
                state_next = ST_D_RD2;
            end
            ST_D_RD2:
                state_next = ST_D_LD;
            ST_D_LD:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (pend1_reg)
                    pend1_next = 1'b0;
                else
                    pend2_next = 1'b0;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (sts.out_done)
                    state_next = (pend1_reg || pend2_reg) ? ST_EMIT : ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
            addr_reg     <= '0;
            em1_reg      <= '0;
            em2_reg      <= '0;
            pend1_reg    <= 1'b0;
            pend2_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            draining_reg <= draining_next;
            addr_reg     <= addr_next;
            em1_reg      <= em1_next;
            em2_reg      <= em2_next;
            pend1_reg    <= pend1_next;
            pend2_reg    <= pend2_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

    always_comb
    begin
        cmd.take = (state_reg == ST_IDLE) && s_tvalid;
        cmd.ld   = (state_reg == ST_P_LD) || (state_reg == ST_D_RD1) ||
                   (state_reg == ST_D_RD2) || (state_reg == ST_D_LD);
        cmd.we   = state_reg == ST_P_LD;
        cmd.go   = state_reg == ST_EMIT;
        cmd.em   = pend1_reg ? em1_reg : em2_reg;
        cmd.addr = addr_reg;
    end

    // a job only starts on an empty averaging pipeline
    assert property (@(posedge clk) disable iff (!rst_n) cmd.go |-> sts.idle)
        else $error("averaging job issued while pipeline busy");

    // while draining, the column counter stays parked at zero
    assert property (@(posedge clk) disable iff (!rst_n) draining_reg |-> col_reg == '0)
        else $error("column counter moved during drain");

    // a result transfer only happens while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_done |-> state_reg == ST_WAIT)
        else $error("result transfer outside wait state");

endmodule

// File: hw/rtl/bb3_dp.sv
// bb3_dp: line stores, 3x3 window and the averaging unit (masked sum,
// reciprocal multiply, output register). Depends on bb3_pkg.
module bb3_dp
    import bb3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bb3_cmd_t    cmd,
    output bb3_sts_t    sts,
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // red_out, green_out, blue_out
    output logic        m_tlast,   // run_end
    output logic [0:0]  m_tuser    // frame_end
);

    pix_t upper_mem [MAX_WIDTH];
    pix_t middle_mem [MAX_WIDTH];
    pix_t up_q_reg;
    pix_t mid_q_reg;
    pix_t pix_reg;
    pix_t win_reg [3][3];

    logic                s1_v_reg;
    logic [SUM_BITS-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [3:0]          n_reg;
    logic                fe_reg, re_reg;
    logic                out_v_reg;
    logic [7:0]          out_r_reg, out_g_reg, out_b_reg;
    logic                out_fe_reg, out_re_reg;

    logic [SUM_BITS-1:0] sum_r, sum_g, sum_b;
    logic [1:0]          rcnt, ccnt;
    logic [3:0]          n_cnt;
    logic [2:0]          rok, cok;
    pix_t                px;
    logic [X_BITS-1:0]   x_r, x_g, x_b;
    logic [PROD_BITS-1:0] p_r, p_g, p_b;
    logic [RECIP_BITS-1:0] rcp;
    logic                adv;

    always_ff @(posedge clk)
    begin
        up_q_reg  <= upper_mem[cmd.addr];
        mid_q_reg <= middle_mem[cmd.addr];
        if (cmd.we)
        begin
            upper_mem[cmd.addr]  <= mid_q_reg;
            middle_mem[cmd.addr] <= pix_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            pix_reg.r <= s_tdata[7:0];
            pix_reg.g <= s_tdata[15:8];
            pix_reg.b <= s_tdata[23:16];
        end
        if (cmd.ld)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= up_q_reg;
            win_reg[1][2] <= mid_q_reg;
            win_reg[2][2] <= pix_reg;
        end
    end

    // masked neighborhood sum; shift picks the window moved one column left
    always_comb
    begin
        rok   = {cmd.em.rok2, 1'b1, cmd.em.rok0};
        cok   = {cmd.em.cok2, 1'b1, cmd.em.cok0};
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        px    = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (cmd.em.shift && j < 2)
                    px = win_reg[i][j + 1];
                else
                    px = win_reg[i][j];
                if (rok[i] && cok[j])
                begin
                    sum_r = sum_r + SUM_BITS'(px.r);
                    sum_g = sum_g + SUM_BITS'(px.g);
                    sum_b = sum_b + SUM_BITS'(px.b);
                end
            end
        end
        rcnt  = 2'd1 + 2'(cmd.em.rok0) + 2'(cmd.em.rok2);
        ccnt  = 2'd1 + 2'(cmd.em.cok0) + 2'(cmd.em.cok2);
        n_cnt = 4'(rcnt) * 4'(ccnt);
    end

    // mean = floor((2*sum + n) / (2*n)) by reciprocal multiply
    always_comb
    begin
        rcp = recip(n_reg);
        x_r = {sum_r_reg, 1'b0} + X_BITS'(n_reg);
        x_g = {sum_g_reg, 1'b0} + X_BITS'(n_reg);
        x_b = {sum_b_reg, 1'b0} + X_BITS'(n_reg);
        p_r = PROD_BITS'(x_r) * PROD_BITS'(rcp);
        p_g = PROD_BITS'(x_g) * PROD_BITS'(rcp);
        p_b = PROD_BITS'(x_b) * PROD_BITS'(rcp);
    end

    assign adv = s1_v_reg && (!out_v_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (cmd.go)
                s1_v_reg <= 1'b1;
            else if (adv)
                s1_v_reg <= 1'b0;
            if (adv)
                out_v_reg <= 1'b1;
            else if (m_tready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            sum_r_reg <= sum_r;
            sum_g_reg <= sum_g;
            sum_b_reg <= sum_b;
            n_reg     <= n_cnt;
            fe_reg    <= cmd.em.frame_end;
            re_reg    <= cmd.em.run_end;
        end
        if (adv)
        begin
            out_r_reg  <= p_r[RECIP_BITS +: 8];
            out_g_reg  <= p_g[RECIP_BITS +: 8];
            out_b_reg  <= p_b[RECIP_BITS +: 8];
            out_fe_reg <= fe_reg;
            out_re_reg <= re_reg;
        end
    end

    assign m_tvalid     = out_v_reg;
    assign m_tdata      = {out_b_reg, out_g_reg, out_r_reg};
    assign m_tlast      = out_re_reg;
    assign m_tuser      = out_fe_reg;
    assign sts.idle     = !s1_v_reg && !out_v_reg;
    assign sts.out_done = out_v_reg && m_tready;

endmodule

// File: hw/rtl/box_blur_3x3_edge_clamped.sv
// Box blur 3x3, edge clamped, over one RGB frame in raster order. A pixel
// transfer reads the line stores, then loads the window and writes them back;
// each result is then issued and held until the sink takes it. A drain
// transfer reads three columns in turn before its result. This order comes
// from the single read port of each line store and the one averaging unit
// that all results share. Results appear one row late, with the last row
// given by drain transfers after the frame. Image size is to be written over
// APB while the block is idle; the block does not enforce it. Depends on bb3_pkg.
module box_blur_3x3_edge_clamped
    import bb3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red_in, green_in, blue_in
    input  logic [0:0]  s_tuser,    // cmd (1 = drain)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // red_out, green_out, blue_out
    output logic        m_tlast,    // run_end
    output logic [0:0]  m_tuser,    // frame_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic          wr_en;
    reg_idx_t      widx;
    bb3_cmd_t      cmd;
    bb3_sts_t      sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_WIDTH:  width_reg  <= pwdata[WW-1:0];
                REG_HEIGHT: height_reg <= pwdata[HW-1:0];
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            default:    prdata = '0;
        endcase
    end

    bb3_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .item_drain   (s_tuser[0]),
        .image_width  (width_reg),
        .image_height (height_reg),
        .sts          (sts),
        .cmd          (cmd)
    );

    bb3_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
